### hw/rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int ID_W          = 16;
    localparam int PRIO_W        = 8;
    localparam int STATUS_W      = 2;
    localparam int COUNT_OUT_W   = 5;

    // operation codes on func
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } spq_status_t;

    // one held entry
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } spq_slot_t;

    // operation broadcast to every cell
    typedef struct packed {
        logic              ins;  // insert that is not refused
        logic              rem;  // remove whose id was found
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } spq_op_t;

endpackage

### hw/rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the queue: holds an entry, compares it against the broadcast
// operation and shifts with its neighbours.
// ----------------------------------------------------------------------------
module spq_cell
(
    input  logic               clk,
    input  spq_pkg::spq_op_t   op,
    input  logic               occupied,
    input  logic               prev_keep,   // slot ahead keeps its entry
    input  spq_pkg::spq_slot_t prev_slot,
    input  spq_pkg::spq_slot_t next_slot,
    input  logic               found_in,    // id matched in a slot ahead
    output logic               keep,
    output logic               found_out,
    output spq_pkg::spq_slot_t slot
);

    spq_pkg::spq_slot_t slot_reg;
    spq_pkg::spq_slot_t slot_next;

    // equal priorities stay ahead of the new entry
    assign keep      = occupied && (slot_reg.prio >= op.prio);
    assign found_out = found_in || (occupied && (slot_reg.id == op.id));
    assign slot      = slot_reg;

    always_comb
    begin
        slot_next = slot_reg;
        if (op.ins && !keep)
        begin
            if (prev_keep)
            begin
                slot_next.id   = op.id;
                slot_next.prio = op.prio;
            end
            else
            begin
                slot_next = prev_slot;
            end
        end
        else if (op.rem && found_out)
        begin
            // the matching slot and all behind it move one forward
            slot_next = next_slot;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

endmodule

### hw/rtl/sorted_priority_queue_top.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_top
// Shift-register priority queue built from a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Every slot decides its next content combinationally in the cycle of the
// transfer, so the queue takes one operation per cycle for as long as the
// result side does not stall; the result register holds one result and the
// input stalls while that result waits. The critical path is the id
// compare in each cell followed by the first-match chain that runs along the
// row of DEPTH cells on a remove. Entries are sorted by priority, highest at
// the head, earlier arrivals first among equals; inserts into a full queue are
// refused and removes of an absent id report not found, leaving the queue as
// it was. Slot contents have no reset: only occupied slots are ever shown.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top
#(
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          func,
    input  logic [spq_pkg::ID_W-1:0]      proc_id,
    input  logic [spq_pkg::PRIO_W-1:0]    proc_priority,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [spq_pkg::STATUS_W-1:0]  status,
    output logic [spq_pkg::COUNT_OUT_W-1:0] entry_count,
    output logic                          head_valid,
    output logic [spq_pkg::ID_W-1:0]      head_id,
    output logic [spq_pkg::PRIO_W-1:0]    head_priority
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int EXT_W = (CNT_W > spq_pkg::COUNT_OUT_W) ? CNT_W : spq_pkg::COUNT_OUT_W;

    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    spq_pkg::spq_status_t    status_reg;
    spq_pkg::spq_status_t    status_next;

    logic                    in_fire;
    logic                    is_full;
    logic                    found;
    spq_pkg::spq_op_t        op;

    logic                    keep    [DEPTH];
    logic                    found_c [DEPTH];
    spq_pkg::spq_slot_t      slot_c  [DEPTH];
    logic [EXT_W-1:0]        count_ext;

    assign in_stall = out_valid_reg && out_stall;
    assign in_fire  = in_valid && !in_stall;
    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign found    = found_c[DEPTH-1];

    assign op.ins  = in_fire && (func == spq_pkg::FUNC_INSERT) && !is_full;
    assign op.rem  = in_fire && (func == spq_pkg::FUNC_REMOVE) && found;
    assign op.id   = proc_id;
    assign op.prio = proc_priority;

    genvar k;
    generate
        for (k = 0; k < DEPTH; k++)
        begin : g_cell
            logic               prev_keep_k;
            logic               found_in_k;
            spq_pkg::spq_slot_t prev_slot_k;
            spq_pkg::spq_slot_t next_slot_k;

            if (k == 0)
            begin : g_head
                assign prev_keep_k = 1'b1;
                assign found_in_k  = 1'b0;
                assign prev_slot_k = slot_c[0];
            end
            else
            begin : g_body
                assign prev_keep_k = keep[k-1];
                assign found_in_k  = found_c[k-1];
                assign prev_slot_k = slot_c[k-1];
            end

            if (k == DEPTH - 1)
            begin : g_tail
                assign next_slot_k = slot_c[k];
            end
            else
            begin : g_inner
                assign next_slot_k = slot_c[k+1];
            end

            spq_cell u_cell
            (
                .clk       (clk),
                .op        (op),
                .occupied  (CNT_W'(k) < count_reg),
                .prev_keep (prev_keep_k),
                .prev_slot (prev_slot_k),
                .next_slot (next_slot_k),
                .found_in  (found_in_k),
                .keep      (keep[k]),
                .found_out (found_c[k]),
                .slot      (slot_c[k])
            );
        end
    endgenerate

    always_comb
    begin
        count_next     = count_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (in_fire)
        begin
            out_valid_next = 1'b1;
            if (func == spq_pkg::FUNC_INSERT)
            begin
                if (is_full)
                begin
                    status_next = spq_pkg::ST_FULL;
                end
                else
                begin
                    status_next = spq_pkg::ST_OK;
                    count_next  = count_reg + CNT_W'(1);
                end
            end
            else
            begin
                if (found)
                begin
                    status_next = spq_pkg::ST_OK;
                    count_next  = count_reg - CNT_W'(1);
                end
                else
                begin
                    status_next = spq_pkg::ST_NOT_FOUND;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= spq_pkg::ST_OK;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
        end
    end

    // cells and count only move on a transfer, so the head view holds while stalled
    assign count_ext     = EXT_W'(count_reg);
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign entry_count   = count_ext[spq_pkg::COUNT_OUT_W-1:0];
    assign head_valid    = (count_reg != '0);
    assign head_id       = head_valid ? slot_c[0].id : '0;
    assign head_priority = head_valid ? slot_c[0].prio : '0;

endmodule
